### sv/bps_pkg.sv
// Shared constants, types and register indexes for the byte pattern search block.
`default_nettype none
package bps_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int POSITION_BITS     = 32;

  localparam int BYTE_BITS       = 8;
  localparam int PATTERN_BITS    = BYTE_BITS * MAX_PATTERN_BYTES;
  localparam int CFG_DATA_BITS   = 64;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int LEN_BITS        = 4;
  localparam int START_BITS      = 32;
  localparam int MATCH_POS_BITS  = 32;
  localparam int HIST_DEPTH      = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
  localparam int PAT_IDX_BITS    = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int CMP_BITS        = (POSITION_BITS > START_BITS) ? POSITION_BITS : START_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_START_POSITION = 2'd2
  } cfg_reg_t;

  typedef logic [BYTE_BITS-1:0]                         byte_t;
  typedef logic [POSITION_BITS-1:0]                     pos_t;
  typedef logic [HIST_DEPTH-1:0][BYTE_BITS-1:0]         hist_t;
  typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_BITS-1:0]  pattern_t;

  typedef struct packed {
    pattern_t                pattern;
    logic [LEN_BITS-1:0]     length;
    logic [START_BITS-1:0]   start_position;
  } search_cfg_t;

  typedef struct packed {
    logic hit;
    pos_t start;
  } window_match_t;

  typedef struct packed {
    logic                      found;
    logic [MATCH_POS_BITS-1:0] match_position;
  } search_result_t;

endpackage
`default_nettype wire

### sv/bps_match.sv
// Parallel compare of the current byte window against the configured pattern.
`default_nettype none
module bps_match (
  input  var bps_pkg::search_cfg_t   cfg,
  input  var bps_pkg::byte_t         cur_byte,
  input  var bps_pkg::hist_t         history,
  input  var bps_pkg::pos_t          position,
  output var bps_pkg::window_match_t result
);
  import bps_pkg::*;

  logic [LEN_BITS-1:0]          len_eff;
  byte_t                        window [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic                         enough;
  pos_t                         start;

  // Clamp length into 1..MAX_PATTERN_BYTES.
  always_comb begin
    if (cfg.length == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (cfg.length > LEN_BITS'(MAX_PATTERN_BYTES)) begin
      len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = cfg.length;
    end
  end

  // Window entry k is the byte k places back from the current one.
  always_comb begin
    window[0] = cur_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      window[k] = history[k-1];
    end
  end

  always_comb begin
    logic [LEN_BITS-1:0] pidx;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      pidx = len_eff - LEN_BITS'(1) - LEN_BITS'(k);
      if (LEN_BITS'(k) < len_eff) begin
        byte_ok[k] = (cfg.pattern[pidx[PAT_IDX_BITS-1:0]] == window[k]);
      end else begin
        byte_ok[k] = 1'b1;
      end
    end
  end

  assign enough = ({1'b0, position} + (POSITION_BITS+1)'(1)) >= (POSITION_BITS+1)'(len_eff);
  assign start  = position - POSITION_BITS'(len_eff - LEN_BITS'(1));

  assign result.hit   = enough && (&byte_ok) &&
                        (CMP_BITS'(start) >= CMP_BITS'(cfg.start_position));
  assign result.start = start;

endmodule
`default_nettype wire

### sv/bps_tracker.sv
// Per-buffer state: byte history, saturating position and first-match record.
`default_nettype none
module bps_tracker (
  input  var logic                    clk,
  input  var logic                    rst,
  input  var logic                    step,
  input  var logic                    step_last,
  input  var bps_pkg::byte_t          step_byte,
  input  var bps_pkg::window_match_t  window_hit,
  output var bps_pkg::hist_t          history,
  output var bps_pkg::pos_t           position,
  output var bps_pkg::search_result_t result
);
  import bps_pkg::*;

  localparam pos_t POS_MAX = '1;

  logic match_seen;
  pos_t first_start;
  logic match_seen_next;
  pos_t first_start_next;

  always_comb begin
    match_seen_next  = match_seen;
    first_start_next = first_start;
    if (window_hit.hit && !match_seen) begin
      match_seen_next  = 1'b1;
      first_start_next = window_hit.start;
    end
  end

  assign result.found          = match_seen_next;
  assign result.match_position = match_seen_next ? MATCH_POS_BITS'(first_start_next) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      history     <= '0;
      position    <= '0;
      match_seen  <= 1'b0;
      first_start <= '0;
    end else if (step) begin
      if (step_last) begin
        history     <= '0;
        position    <= '0;
        match_seen  <= 1'b0;
        first_start <= '0;
      end else begin
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
          history[k] <= history[k-1];
        end
        history[0]  <= step_byte;
        if (position != POS_MAX) begin
          position <= position + POSITION_BITS'(1);
        end
        match_seen  <= match_seen_next;
        first_start <= first_start_next;
      end
    end
  end

endmodule
`default_nettype wire

### sv/byte_pattern_search_core.sv
// Top level of the streaming byte pattern search block.
//
// Usage: load the pattern over the cfg channel (index 0 pattern bytes, first
// byte in bits 7:0; index 1 pattern length 1..8; index 2 start position) while
// no buffer is in flight; cfg_ready is always high. Then stream buffer bytes
// on the input channel, one byte per transfer, with last_byte set on the
// final byte. Only a match starting at or after the start position counts.
// The transfer that carries last_byte produces exactly one result transfer:
// found and match_position of the first counted match (position 0 if none).
// Other bytes produce no output.
// Timing: a byte is registered at its input transfer and compared from the
// input register; the result register loads when the last byte steps out.
// Throughput: one byte per cycle while no last byte waits on a full, stalled
// result register, set by the single compare stage between the input
// register and the result register.
// Reset clears the configuration to pattern 0, length 1, start 0 and empties
// the per-buffer state and both registers. When the receiver stalls, the
// result holds in the output register; bytes that end no buffer keep flowing,
// and a second last byte waits in the input register until the result drains.
`default_nettype none
module byte_pattern_search_core (
  input  var logic                               clk,
  input  var logic                               rst,
  input  var logic                               cfg_valid,
  output var logic                               cfg_ready,
  input  var logic [bps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  var logic [bps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  var logic                               in_valid,
  output var logic                               in_ready,
  input  var logic [7:0]                         data_byte,
  input  var logic                               last_byte,
  output var logic                               out_valid,
  input  var logic                               out_ready,
  output var logic                               found,
  output var logic [31:0]                        match_position
);
  import bps_pkg::*;

  search_cfg_t    cfg;
  logic           s1_valid;
  byte_t          s1_byte;
  logic           s1_last;
  logic           step;
  hist_t          history;
  pos_t           position;
  window_match_t  window_hit;
  search_result_t result;

  // Configuration: always ready; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern        <= '0;
      cfg.length         <= LEN_BITS'(1);
      cfg.start_position <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:  cfg.pattern        <= cfg_data[PATTERN_BITS-1:0];
        REG_PATTERN_LENGTH: cfg.length         <= cfg_data[LEN_BITS-1:0];
        REG_START_POSITION: cfg.start_position <= cfg_data[START_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held byte unless it ends a buffer and the result slot is full and stalled.
  assign step     = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  bps_match u_match (
    .cfg      (cfg),
    .cur_byte (s1_byte),
    .history  (history),
    .position (position),
    .result   (window_hit)
  );

  bps_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .step_last  (s1_last),
    .step_byte  (s1_byte),
    .window_hit (window_hit),
    .history    (history),
    .position   (position),
    .result     (result)
  );

  // Result register: load on a finished buffer, drop after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last) begin
      found          <= result.found;
      match_position <= result.match_position;
    end
  end

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the streaming byte pattern search core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bps_pkg::*;

  // Cycles to let pass after the last result so that bytes that end no
  // buffer have left the two-stage pipe before the next register write.
  localparam int DRAIN_CYCLES = 6;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  localparam int TOTAL_BYTES  = 1700;
  localparam int MAX_REPORTS  = 10;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  byte_t                     data_byte;
  logic                      last_byte;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      found;
  logic [MATCH_POS_BITS-1:0] match_position;

  byte_pattern_search_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .match_position (match_position)
  );

  // Shadow copy of the configuration registers, updated on each cfg transfer.
  pattern_t              pat_cfg;
  logic [LEN_BITS-1:0]   len_cfg;
  logic [START_BITS-1:0] start_cfg;

  // Shadow copy of the per-buffer search state.
  hist_t window_hist;   // entry 0 holds the most recent byte
  pos_t  next_pos;
  logic  seen;
  pos_t  first_start;

  search_result_t search_results_due[$];
  search_result_t oldest_result;

  int          failures = 0;
  int          bytes_sent = 0;
  int          idle_cycles = 0;
  int unsigned hold_left = 0;
  logic        steady = 1'b0;   // no gaps on either side while set
  byte_t       alpha0, alpha1;  // small alphabet that makes near misses common

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pick a gap length: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // A length of 0 acts as 1; anything past the window acts as a full window.
  function automatic int unsigned eff_len();
    if (len_cfg == 0) return 1;
    if (len_cfg > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
    return len_cfg;
  endfunction

  function automatic void clear_search();
    window_hist = '0;
    next_pos    = '0;
    seen        = 1'b0;
    first_start = '0;
  endfunction

  // Advance the shadow search by one accepted byte and queue the result that
  // a final byte produces.
  function automatic void search_step(input byte_t b, input logic last);
    int unsigned    n;
    logic           hit;
    pos_t           start;
    search_result_t res;
    n = eff_len();
    // Compare only once a full window of this buffer has arrived.
    if ({1'b0, next_pos} + 1 >= n) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (pat_cfg[n-1-k] != ((k == 0) ? b : window_hist[k-1])) hit = 1'b0;
      end
      start = next_pos - pos_t'(n - 1);
      // Keep only the first match at or after the start position.
      if (hit && (start >= start_cfg) && !seen) begin
        seen        = 1'b1;
        first_start = start;
      end
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) window_hist[k] = window_hist[k-1];
    window_hist[0] = b;
    // Saturate the position rather than wrap.
    if (next_pos != '1) next_pos = next_pos + 1'b1;
    if (last) begin
      res.found          = seen;
      res.match_position = seen ? first_start[MATCH_POS_BITS-1:0] : '0;
      search_results_due.push_back(res);
      clear_search();
    end
  endfunction

  // Receiver: drop out_ready for random stretches.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      hold_left <= pick_gap();
    end
  end

  // Compare each result transfer against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (search_results_due.size() == 0) begin
        if (failures < MAX_REPORTS) begin
          $display("%0t: unexpected result found=%0b match_position=%0d",
                   $realtime, found, match_position);
        end
        failures <= failures + 1;
      end else begin
        oldest_result = search_results_due.pop_front();
        if (found !== oldest_result.found ||
            match_position !== oldest_result.match_position) begin
          if (failures < MAX_REPORTS) begin
            $display("%0t: result mismatch: expected found=%0b pos=%0d, got found=%0b pos=%0d",
                     $realtime, oldest_result.found, oldest_result.match_position,
                     found, match_position);
          end
          failures <= failures + 1;
        end
      end
    end
  end

  // Watchdog: end the run if no channel makes progress for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one byte after a random gap, hold it until the transfer, then
  // advance the shadow search. Valid stays high for a back-to-back byte.
  task automatic send_byte(input byte_t b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    search_step(b, last);
    bytes_sent++;
  endtask

  task automatic send_buffer(input byte_t chunk[$]);
    foreach (chunk[i]) send_byte(chunk[i], i == chunk.size() - 1);
  endtask

  // Hold the sender until every result has arrived, then let the pipe drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (search_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PATTERN_BYTES:  pat_cfg   = value;
      REG_PATTERN_LENGTH: len_cfg   = value[LEN_BITS-1:0];
      REG_START_POSITION: start_cfg = value[START_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] pat, input logic [63:0] len,
                            input logic [63:0] start);
    wait_idle();
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, len);
    write_reg(REG_START_POSITION, start);
  endtask

  // Reset values: single zero byte pattern, start at 0. The first of two
  // matches wins, and a one-byte buffer matches at position 0.
  task automatic test_default_config();
    send_buffer('{8'h5A, 8'h00, 8'h00});
    send_buffer('{8'h00});
  endtask

  // Length 0 acts as 1 with junk above the pattern, length 15 acts as a full
  // window, and a buffer shorter than the pattern never matches.
  task automatic test_length_limits();
    set_config(64'hA5A5_A5A5_A5A5_A5FF, 0, 0);
    send_buffer('{8'hFF});
    set_config(64'h0706_0504_0302_0100, 15, 0);
    send_buffer('{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07});
    send_buffer('{8'h00, 8'h01, 8'h02});
  endtask

  // Matches before the start position do not count; the largest start
  // position rules out every match.
  task automatic test_start_position();
    set_config(64'h0, 1, 2);
    send_buffer('{8'h00, 8'h00, 8'h00});
    set_config(64'hFFFF_FFFF_FFFF_FF00, 1, 64'hFFFF_FFFF);
    send_buffer('{8'h00});
  endtask

  // Shorten the pattern between two bytes of one buffer: the new length
  // applies from the next byte on.
  task automatic test_midbuffer_config();
    set_config(64'h3C3C, 2, 0);
    send_byte(8'h3C, 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 1);
    send_byte(8'h3C, 1'b1);
  endtask

  task automatic new_random_config();
    pattern_t    pat;
    logic [63:0] len;
    logic [63:0] start;
    int unsigned r;
    alpha0 = $urandom_range(255);
    alpha1 = $urandom_range(255);
    r = $urandom_range(99);
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      pat[k] = ($urandom_range(9) < 7) ? ($urandom_range(1) ? alpha0 : alpha1)
                                       : byte_t'($urandom_range(255));
    end
    if (r < 5) pat = '0;
    else if (r < 10) pat = '1;
    r = $urandom_range(99);
    if (r < 10) len = 0;
    else if (r < 20) len = $urandom_range(15, 9);
    else len = $urandom_range(MAX_PATTERN_BYTES, 1);
    r = $urandom_range(99);
    if (r < 40) start = 0;
    else if (r < 80) start = $urandom_range(24);
    else if (r < 90) start = $urandom();
    else start = 64'hFFFF_FFFF;
    set_config(pat, len, start);
  endtask

  // Build one buffer: most carry the pattern once or twice, some carry a
  // damaged copy, the rest are noise.
  task automatic send_random_buffer();
    byte_t       chunk[$];
    int unsigned size, n, r, at;
    size = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range(80, 25);
    n = eff_len();
    for (int i = 0; i < size; i++) begin
      r = $urandom_range(9);
      if (r < 3) chunk.push_back(alpha0);
      else if (r < 5) chunk.push_back(alpha1);
      else if (r < 7) chunk.push_back(pat_cfg[$urandom_range(MAX_PATTERN_BYTES - 1)]);
      else chunk.push_back(byte_t'($urandom_range(255)));
    end
    r = $urandom_range(99);
    if (r < 85 && size >= n) begin
      for (int copies = (r < 35) ? 2 : 1; copies > 0; copies--) begin
        at = $urandom_range(size - n);
        for (int k = 0; k < n; k++) chunk[at+k] = pat_cfg[k];
        // Damage one byte of the copy.
        if (r >= 70) chunk[at + $urandom_range(n - 1)] ^= byte_t'($urandom_range(255, 1));
      end
    end
    send_buffer(chunk);
  endtask

  task automatic test_random_mix();
    int phase_end;
    while (bytes_sent < TOTAL_BYTES) begin
      new_random_config();
      steady = ($urandom_range(4) == 0);
      phase_end = bytes_sent + $urandom_range(200, 100);
      while (bytes_sent < phase_end && bytes_sent < TOTAL_BYTES) send_random_buffer();
      steady = 1'b0;
    end
  endtask

  initial begin
    cfg_valid <= 1'b0;
    cfg_index <= REG_PATTERN_BYTES;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    data_byte <= '0;
    last_byte <= 1'b0;
    rst       <= 1'b1;
    // Mirror the reset state: pattern 0, length 1, start 0.
    pat_cfg   = '0;
    len_cfg   = 1;
    start_cfg = '0;
    clear_search();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_default_config();
    test_length_limits();
    test_start_position();
    test_midbuffer_config();
    test_random_mix();

    // Wait for the last results, then let the pipe settle.
    wait_idle();
    if (failures == 0 && search_results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### byte_pattern_search_core.f
sv/bps_pkg.sv
sv/bps_match.sv
sv/bps_tracker.sv
sv/byte_pattern_search_core.sv
tb/tb.sv
